// ----- src/alle_pkg.sv -----
// ----------------------------------------------------------------------------
// Array linked list engine package
// Shared widths, request and status codes, and the word types that the
// engine and its slot store exchange.
// ----------------------------------------------------------------------------
package alle_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int LNK_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;

  localparam logic [LNK_W-1:0] NIL = LNK_W'(DEPTH);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic signed [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] out_value;
    logic [IDX_W-1:0]        slot_index;
    logic [LNK_W-1:0]        next_index;
    logic                    is_empty;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    val_we;
    logic                    lnk_we;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [VAL_W-1:0] val_data;
    logic [LNK_W-1:0]        lnk_data;
  } mem_req_t;

endpackage

// ----- src/alle_store.sv -----
// ----------------------------------------------------------------------------
// Slot store
// Value and link memories with one write port and one registered read port.
// Link entries never written read as the next slot index.
// ----------------------------------------------------------------------------
module alle_store (
  input  logic                             clk,
  input  logic                             rst,
  input  alle_pkg::mem_req_t               mreq,
  output logic signed [alle_pkg::VAL_W-1:0] val_rd,
  output logic [alle_pkg::LNK_W-1:0]       lnk_rd
);
  import alle_pkg::*;

  logic signed [VAL_W-1:0] val_mem [DEPTH];
  logic [LNK_W-1:0]        lnk_mem [DEPTH];
  logic [DEPTH-1:0]        lnk_ok;
  logic [LNK_W-1:0]        lnk_q;
  logic                    rd_ok_q;
  logic [IDX_W-1:0]        rd_addr_q;

  always_ff @(posedge clk) begin
    if (mreq.val_we) begin
      val_mem[mreq.wr_addr] <= mreq.val_data;
    end
    if (mreq.lnk_we) begin
      lnk_mem[mreq.wr_addr] <= mreq.lnk_data;
    end
    if (mreq.rd_en) begin
      val_rd    <= val_mem[mreq.rd_addr];
      lnk_q     <= lnk_mem[mreq.rd_addr];
      rd_ok_q   <= lnk_ok[mreq.rd_addr];
      rd_addr_q <= mreq.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lnk_ok <= '0;
    end else if (mreq.lnk_we) begin
      lnk_ok[mreq.wr_addr] <= 1'b1;
    end
  end

  assign lnk_rd = rd_ok_q ? lnk_q : ({1'b0, rd_addr_q} + LNK_W'(1));

endmodule

// ----- src/array_linked_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// Array linked list engine
// Singly linked list over a fixed slot pool with a LIFO free list.
// Dump emits one word per cycle, DEPTH at most, set by the one read port of the
// slot store. Results appear in the cycle after they are decided; the receiver
// cannot stall.
// Synchronous reset empties the list and puts every slot on the free list.
// ----------------------------------------------------------------------------
module array_linked_list_engine_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  alle_pkg::req_t req,
  output logic           rsp_valid,
  output alle_pkg::rsp_t rsp
);
  import alle_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_INS     = 6'b000010,
    S_INS_LNK = 6'b000100,
    S_RM      = 6'b001000,
    S_RM_LNK  = 6'b010000,
    S_DUMP    = 6'b100000
  } state_t;

  state_t                  state, state_next;
  logic [LNK_W-1:0]        head, head_next;
  logic [LNK_W-1:0]        tail, tail_next;
  logic [LNK_W-1:0]        free_ptr, free_next;
  logic [LNK_W-1:0]        prev, prev_next;
  logic [LNK_W-1:0]        succ, succ_next;
  logic [LNK_W-1:0]        steps, steps_next;
  logic [IDX_W-1:0]        cur, cur_next;
  logic [IDX_W-1:0]        cnt, cnt_next;
  logic signed [VAL_W-1:0] key, key_next;
  logic                    rsp_valid_next;
  rsp_t                    rsp_next;
  mem_req_t                mreq;
  logic signed [VAL_W-1:0] val_rd;
  logic [LNK_W-1:0]        lnk_rd;
  logic                    fin;

  function automatic rsp_t make_rsp(input logic [1:0] st, input logic signed [VAL_W-1:0] v,
                                    input logic [IDX_W-1:0] s, input logic [LNK_W-1:0] n,
                                    input logic e, input logic l);
    rsp_t r;
    r.status     = st;
    r.out_value  = v;
    r.slot_index = s;
    r.next_index = n;
    r.is_empty   = e;
    r.last       = l;
    return r;
  endfunction

  alle_store u_store (
    .clk    (clk),
    .rst    (rst),
    .mreq   (mreq),
    .val_rd (val_rd),
    .lnk_rd (lnk_rd)
  );

  assign busy = (state != S_IDLE);
  assign fin  = (lnk_rd == NIL) || (cnt == IDX_W'(DEPTH - 1));

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    free_next      = free_ptr;
    prev_next      = prev;
    succ_next      = succ;
    steps_next     = steps;
    cur_next       = cur;
    cnt_next       = cnt;
    key_next       = key;
    rsp_valid_next = 1'b0;
    rsp_next       = make_rsp(ST_MISS, '0, '0, NIL, 1'b0, 1'b1);
    mreq           = '0;
    mreq.val_data  = key;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          key_next = req.item_value;
          case (req.req_type)
            REQ_INSERT: begin
              if (free_ptr == NIL) begin
                rsp_valid_next = 1'b1;
                rsp_next = make_rsp(ST_FULL, '0, '0, NIL, head == NIL, 1'b1);
              end else begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = free_ptr[IDX_W-1:0];
                cur_next     = free_ptr[IDX_W-1:0];
                state_next   = S_INS;
              end
            end
            REQ_REMOVE, REQ_DUMP: begin
              if (head == NIL) begin
                rsp_valid_next = 1'b1;
                rsp_next = make_rsp(ST_MISS, '0, '0, NIL, 1'b1, 1'b1);
              end else begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = head[IDX_W-1:0];
                cur_next     = head[IDX_W-1:0];
                prev_next    = NIL;
                steps_next   = '0;
                cnt_next     = '0;
                state_next   = (req.req_type == REQ_DUMP) ? S_DUMP : S_RM;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS: begin
        free_next      = lnk_rd;
        mreq.val_we    = 1'b1;
        mreq.lnk_we    = 1'b1;
        mreq.wr_addr   = cur;
        mreq.lnk_data  = NIL;
        rsp_valid_next = 1'b1;
        rsp_next       = make_rsp(ST_OK, key, cur, NIL, 1'b0, 1'b1);
        if (head == NIL) begin
          head_next  = {1'b0, cur};
          tail_next  = {1'b0, cur};
          state_next = S_IDLE;
        end else if (tail != NIL) begin
          state_next = S_INS_LNK;
        end else begin
          tail_next  = {1'b0, cur};
          state_next = S_IDLE;
        end
      end
      S_INS_LNK: begin
        mreq.lnk_we   = 1'b1;
        mreq.wr_addr  = tail[IDX_W-1:0];
        mreq.lnk_data = {1'b0, cur};
        tail_next     = {1'b0, cur};
        state_next    = S_IDLE;
      end
      S_RM: begin
        if (val_rd == key) begin
          rsp_valid_next = 1'b1;
          rsp_next = make_rsp(ST_OK, val_rd, cur, lnk_rd,
                              (prev == NIL) && (lnk_rd == NIL), 1'b1);
          mreq.lnk_we   = 1'b1;
          mreq.wr_addr  = cur;
          mreq.lnk_data = free_ptr;
          free_next     = {1'b0, cur};
          if (prev == NIL) begin
            head_next = lnk_rd;
            if (lnk_rd == NIL) begin
              tail_next = NIL;
            end
            state_next = S_IDLE;
          end else begin
            succ_next = lnk_rd;
            if ({1'b0, cur} == tail) begin
              tail_next = prev;
            end
            state_next = S_RM_LNK;
          end
        end else if ((lnk_rd == NIL) || (steps == LNK_W'(DEPTH - 1))) begin
          rsp_valid_next = 1'b1;
          rsp_next = make_rsp(ST_MISS, '0, '0, NIL, head == NIL, 1'b1);
          state_next = S_IDLE;
        end else begin
          prev_next    = {1'b0, cur};
          cur_next     = lnk_rd[IDX_W-1:0];
          steps_next   = steps + LNK_W'(1);
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = lnk_rd[IDX_W-1:0];
        end
      end
      S_RM_LNK: begin
        mreq.lnk_we   = 1'b1;
        mreq.wr_addr  = prev[IDX_W-1:0];
        mreq.lnk_data = succ;
        state_next    = S_IDLE;
      end
      S_DUMP: begin
        rsp_valid_next = 1'b1;
        rsp_next = make_rsp(ST_OK, val_rd, cur, lnk_rd, 1'b0, fin);
        if (fin) begin
          state_next = S_IDLE;
        end else begin
          cur_next     = lnk_rd[IDX_W-1:0];
          cnt_next     = cnt + IDX_W'(1);
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = lnk_rd[IDX_W-1:0];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NIL;
      tail      <= NIL;
      free_ptr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      free_ptr  <= free_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    prev  <= prev_next;
    succ  <= succ_next;
    steps <= steps_next;
    cur   <= cur_next;
    cnt   <= cnt_next;
    key   <= key_next;
    rsp   <= rsp_next;
  end

endmodule

// ----- src/alle_checker.sv -----
// ----------------------------------------------------------------------------
// Array linked list engine checker
// Port-level properties of the result words, bound to the top level.
// ----------------------------------------------------------------------------
module alle_checker (
  input logic           clk,
  input logic           rst,
  input logic           busy,
  input logic           rsp_valid,
  input alle_pkg::rsp_t rsp
);
  import alle_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !busy && !rsp_valid)
    else $error("Engine not quiet after reset.");

  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |->
      rsp.last && (rsp.out_value == 0) && (rsp.slot_index == 0) && (rsp.next_index == NIL))
    else $error("Failed request word is malformed.");

  a_dump_more: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> (rsp.status == ST_OK) && !rsp.is_empty && (rsp.next_index != NIL))
    else $error("Intermediate dump word is malformed.");

  a_dump_cont: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |=> rsp_valid)
    else $error("Dump stream broke before its last word.");

endmodule

bind array_linked_list_engine_unit alle_checker u_alle_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .rsp_valid (rsp_valid),
  .rsp       (rsp)
);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Array linked list engine testbench
// Drives insert, remove and dump requests through the start/busy handshake and
// checks every result word against a slot pool model kept in a small class.
// A directed opening fills, overflows, dumps and removes from the list, then a long random
// run alternates between filling and draining with random idle bursts.
// ----------------------------------------------------------------------------
module tb;
  import alle_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 290;
  localparam int CYCLE_LIMIT  = 400000;

  class slot_list_model;
    logic signed [VAL_W-1:0] slot_val [DEPTH];
    logic [LNK_W-1:0]        slot_link [DEPTH];
    logic [LNK_W-1:0]        head, tail, free_head;
    rsp_t                    pending_rsp [$];
    int                      errors;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        slot_val[i]  = '0;
        slot_link[i] = LNK_W'(i + 1);
      end
      head      = NIL;
      tail      = NIL;
      free_head = '0;
      errors    = 0;
    endfunction

    function int live_count();
      logic [LNK_W-1:0] cur;
      int n;
      cur = head;
      n = 0;
      while (cur < DEPTH && n < DEPTH) begin
        n++;
        cur = slot_link[cur[IDX_W-1:0]];
      end
      return n;
    endfunction

    function logic signed [VAL_W-1:0] pick_live_value();
      logic [LNK_W-1:0] cur;
      int k;
      cur = head;
      k = $urandom_range(0, live_count() - 1);
      repeat (k) cur = slot_link[cur[IDX_W-1:0]];
      return slot_val[cur[IDX_W-1:0]];
    endfunction

    function void push_rsp(logic [1:0] st, logic signed [VAL_W-1:0] v,
                           logic [LNK_W-1:0] slot, logic [LNK_W-1:0] nxt, logic fin);
      rsp_t r;
      r.status     = st;
      r.out_value  = v;
      r.slot_index = slot[IDX_W-1:0];
      r.next_index = nxt;
      r.is_empty   = (head >= DEPTH);
      r.last       = fin;
      pending_rsp.push_back(r);
    endfunction

    function void apply_request(req_t r);
      logic [LNK_W-1:0] cur, prev, succ;
      int steps;
      case (r.req_type)
        REQ_INSERT: begin
          if (free_head >= DEPTH) begin
            push_rsp(ST_FULL, '0, '0, NIL, 1'b1);
          end else begin
            cur = free_head;
            free_head = slot_link[cur[IDX_W-1:0]];
            slot_val[cur[IDX_W-1:0]]  = r.item_value;
            slot_link[cur[IDX_W-1:0]] = NIL;
            if (head >= DEPTH) head = cur;
            else if (tail < DEPTH) slot_link[tail[IDX_W-1:0]] = cur;
            tail = cur;
            push_rsp(ST_OK, r.item_value, cur, NIL, 1'b1);
          end
        end
        REQ_REMOVE: begin
          cur = head;
          prev = NIL;
          steps = 0;
          while (cur < DEPTH && steps < DEPTH && slot_val[cur[IDX_W-1:0]] != r.item_value) begin
            prev = cur;
            cur = slot_link[cur[IDX_W-1:0]];
            steps++;
          end
          if (cur >= DEPTH || steps >= DEPTH) begin
            push_rsp(ST_MISS, '0, '0, NIL, 1'b1);
          end else begin
            succ = slot_link[cur[IDX_W-1:0]];
            if (prev >= DEPTH) begin
              head = succ;
              if (head >= DEPTH) tail = NIL;
            end else begin
              slot_link[prev[IDX_W-1:0]] = succ;
              if (cur == tail) tail = prev;
            end
            slot_link[cur[IDX_W-1:0]] = free_head;
            free_head = cur;
            push_rsp(ST_OK, slot_val[cur[IDX_W-1:0]], cur, succ, 1'b1);
          end
        end
        REQ_DUMP: begin
          if (head >= DEPTH) begin
            push_rsp(ST_MISS, '0, '0, NIL, 1'b1);
          end else begin
            cur = head;
            steps = 0;
            while (cur < DEPTH && steps < DEPTH) begin
              succ = slot_link[cur[IDX_W-1:0]];
              push_rsp(ST_OK, slot_val[cur[IDX_W-1:0]], cur, succ,
                       succ >= DEPTH || steps == DEPTH - 1);
              steps++;
              cur = succ;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string field, longint want, longint got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void compare_rsp(rsp_t got);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result word, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.out_value !== want.out_value)
        report("out_value", want.out_value, got.out_value);
      if (got.slot_index !== want.slot_index)
        report("slot_index", want.slot_index, got.slot_index);
      if (got.next_index !== want.next_index)
        report("next_index", want.next_index, got.next_index);
      if (got.is_empty !== want.is_empty) report("is_empty", want.is_empty, got.is_empty);
      if (got.last !== want.last) report("last", want.last, got.last);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic rsp_valid;
  rsp_t rsp;

  slot_list_model model = new();
  int cycle_count;

  array_linked_list_engine_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid) model.compare_rsp(rsp);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL array_linked_list_engine_unit");
    $finish;
  end

  task automatic send_request(input logic [1:0] kind, input logic signed [VAL_W-1:0] v);
    req_t r;
    r.req_type   = kind;
    r.item_value = v;
    req   <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    model.apply_request(r);
  endtask

  task automatic idle_burst(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (model.pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 7) - 4;
      4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int counted, phase_left, roll;
    logic filling;
    logic signed [VAL_W-1:0] v;
    logic [1:0] kind;

    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list, unused code, then fill to capacity with one duplicate.
    send_request(REQ_DUMP, 32'sd0);
    send_request(REQ_REMOVE, 32'sd5);
    send_request(REQ_UNUSED, 32'sd9);
    send_request(REQ_INSERT, 32'sh7fffffff);
    send_request(REQ_INSERT, 32'sh80000000);
    send_request(REQ_INSERT, 32'sd0);
    send_request(REQ_INSERT, -32'sd1);
    for (int i = 4; i < DEPTH; i++)
      send_request(REQ_INSERT, (i == 10) ? -32'sd1 : 32'sd100 + i);
    send_request(REQ_INSERT, 32'sd77);
    send_request(REQ_DUMP, 32'sd0);
    // Head, first of two matches, tail, and an absent value.
    send_request(REQ_REMOVE, 32'sh7fffffff);
    send_request(REQ_REMOVE, -32'sd1);
    send_request(REQ_REMOVE, 32'sd100 + DEPTH - 1);
    send_request(REQ_REMOVE, 32'sd12345);

    counted = 0;
    filling = 1'b1;
    phase_left = $urandom_range(20, 50);
    while (counted < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        filling = ~filling;
        phase_left = $urandom_range(20, 50);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (filling)
        kind = (roll < 55) ? REQ_INSERT : (roll < 80) ? REQ_REMOVE :
               (roll < 95) ? REQ_DUMP : REQ_UNUSED;
      else
        kind = (roll < 20) ? REQ_INSERT : (roll < 75) ? REQ_REMOVE :
               (roll < 92) ? REQ_DUMP : REQ_UNUSED;
      if (kind == REQ_REMOVE && model.head < DEPTH && $urandom_range(0, 9) < 8)
        v = model.pick_live_value();
      else
        v = random_value();
      if (kind == REQ_UNUSED) v = $urandom;
      send_request(kind, v);
      if (kind != REQ_UNUSED) counted++;
      if (counted == RANDOM_ITEMS / 2) drain_results();
      else if (counted < RANDOM_ITEMS - 60 && $urandom_range(0, 3) == 0)
        idle_burst($urandom_range(1, 18));
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (model.errors == 0 && model.pending_rsp.size() == 0) begin
      $display("PASS array_linked_list_engine_unit");
    end else begin
      $display("FAIL array_linked_list_engine_unit");
    end
    $finish;
  end

endmodule
